// ===== src/ntf_pkg.sv =====
`timescale 1ns / 1ps

package ntf_pkg;

  // Output format and mantissa precision
  localparam int FRAC_BITS     = 16;
  localparam int MANTISSA_BITS = 24;

  // Musical constants
  localparam int A4_OCT         = 4;
  localparam int A4_SEMI        = 9;
  localparam int CENTS_PER_OCT  = 1200;
  localparam int CENTS_PER_SEMI = 100;

  // Table generation
  localparam logic [63:0] LN2_Q40      = 64'hB17217F7D2;
  localparam int          SERIES_TERMS = 20;

  // Widths
  localparam int FREQ_W   = 32;
  localparam int REF_W    = 9;
  localparam int MANT_W   = MANTISSA_BITS + 1;   // entries lie in [1.0, 2.0)
  localparam int ROM_AW   = $clog2(CENTS_PER_OCT);
  localparam int PROD_W   = REF_W + MANT_W;
  localparam int SHIFT_W  = PROD_W + FREQ_W;
  localparam int EXP_W    = 7;                   // octave exponent, signed
  localparam int SH_W     = 8;                   // scaling shift, signed
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OCTAVE_OFFSET   = 2'd0,
    REG_SEMITONE_OFFSET = 2'd1,
    REG_CENT_OFFSET     = 2'd2,
    REG_REFERENCE_HZ    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0] octave;
    logic [3:0] semitone;
  } ntf_in_t;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic              saturated;
  } ntf_out_t;

  typedef struct packed {
    logic signed [3:0] octave_offset;
    logic signed [4:0] semitone_offset;
    logic signed [7:0] cent_offset;
    logic [REF_W-1:0]  reference_hz;
  } ntf_cfg_t;

  // Write port used to load the mantissa memory after reset
  typedef struct packed {
    logic              we;
    logic [ROM_AW-1:0] addr;
    logic [MANT_W-1:0] data;
  } ntf_fill_t;

  typedef logic [MANT_W-1:0] mant_rom_t [CENTS_PER_OCT];

  // 2^(r/1200) as e^(r*ln2/1200), Taylor series in Q32, rounded to the mantissa width
  function automatic logic [MANT_W-1:0] mant_entry(input int unsigned r);
    logic [63:0]  z;
    logic [63:0]  sum;
    logic [63:0]  t;
    logic [127:0] prod;
    z   = ((64'(r) * LN2_Q40) / 64'(CENTS_PER_OCT) + 64'd128) >> 8;
    sum = 64'd1 << 32;
    t   = 64'd1 << 32;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      prod = 128'(t) * 128'(z);
      t    = 64'(prod >> 32) / 64'(k);
      sum  = sum + t;
    end
    if (MANTISSA_BITS < 32) begin
      sum = (sum + (64'd1 << (31 - MANTISSA_BITS))) >> (32 - MANTISSA_BITS);
    end
    return MANT_W'(sum);
  endfunction

  function automatic mant_rom_t build_rom();
    mant_rom_t rom;
    for (int r = 0; r < CENTS_PER_OCT; r++) begin
      rom[r] = mant_entry(r);
    end
    return rom;
  endfunction

  localparam mant_rom_t MANT_ROM = build_rom();

endpackage

// ===== src/ntf_ram.sv =====
`timescale 1ns / 1ps

module ntf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ntf_datapath.sv =====
`timescale 1ns / 1ps

module ntf_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ntf_pkg::ntf_cfg_t  cfg_i,
  input  ntf_pkg::ntf_fill_t fill_i,
  input  logic               advance_i,
  input  logic               in_fire_i,
  input  ntf_pkg::ntf_in_t   in_word_i,
  output logic               out_valid_o,
  output ntf_pkg::ntf_out_t  out_word_o
);

  localparam int SW = ntf_pkg::SHIFT_W;

  // ---------------- Stage A: cents split into octave exponent and remainder
  logic signed [6:0]  oct_s;
  logic signed [6:0]  semi_s;
  logic signed [12:0] cents_in_oct;
  logic signed [2:0]  q_adj;
  logic signed [12:0] rem_s;
  logic signed [ntf_pkg::EXP_W-1:0] exp_d;
  logic [ntf_pkg::ROM_AW-1:0]       rem_d;

  always_comb begin
    oct_s  = 7'($signed({3'b000, in_word_i.octave})) + 7'(cfg_i.octave_offset)
           - 7'(ntf_pkg::A4_OCT);
    semi_s = 7'($signed({3'b000, in_word_i.semitone})) + 7'(cfg_i.semitone_offset)
           - 7'(ntf_pkg::A4_SEMI);
    cents_in_oct = 13'(semi_s) * 13'(ntf_pkg::CENTS_PER_SEMI) + 13'(cfg_i.cent_offset);
    // floor division by one octave; the partial sum stays within three octaves down
    if (cents_in_oct >= 13'(ntf_pkg::CENTS_PER_OCT)) begin
      q_adj = 3'sd1;
      rem_s = cents_in_oct - 13'(ntf_pkg::CENTS_PER_OCT);
    end else if (cents_in_oct >= 13'sd0) begin
      q_adj = 3'sd0;
      rem_s = cents_in_oct;
    end else if (cents_in_oct >= -13'(ntf_pkg::CENTS_PER_OCT)) begin
      q_adj = -3'sd1;
      rem_s = cents_in_oct + 13'(ntf_pkg::CENTS_PER_OCT);
    end else if (cents_in_oct >= -13'(2 * ntf_pkg::CENTS_PER_OCT)) begin
      q_adj = -3'sd2;
      rem_s = cents_in_oct + 13'(2 * ntf_pkg::CENTS_PER_OCT);
    end else begin
      q_adj = -3'sd3;
      rem_s = cents_in_oct + 13'(3 * ntf_pkg::CENTS_PER_OCT);
    end
    exp_d = ntf_pkg::EXP_W'(oct_s) + ntf_pkg::EXP_W'(q_adj);
    rem_d = rem_s[ntf_pkg::ROM_AW-1:0];
  end

  logic                             va_q;
  logic signed [ntf_pkg::EXP_W-1:0] exp_a_q;
  logic [ntf_pkg::ROM_AW-1:0]       rem_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (advance_i) begin
      va_q <= in_fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      exp_a_q <= exp_d;
      rem_a_q <= rem_d;
    end
  end

  // ---------------- Stage B: mantissa lookup
  logic [ntf_pkg::MANT_W-1:0] mant_b;

  ntf_ram #(
    .WIDTH (ntf_pkg::MANT_W),
    .DEPTH (ntf_pkg::CENTS_PER_OCT)
  ) u_mant_ram (
    .clk_i   (clk_i),
    .we_i    (fill_i.we),
    .waddr_i (fill_i.addr),
    .wdata_i (fill_i.data),
    .re_i    (advance_i),
    .raddr_i (rem_a_q),
    .rdata_o (mant_b)
  );

  logic                            vb_q;
  logic signed [ntf_pkg::SH_W-1:0] sh_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (advance_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      sh_b_q <= ntf_pkg::SH_W'(exp_a_q)
              + ntf_pkg::SH_W'(ntf_pkg::FRAC_BITS - ntf_pkg::MANTISSA_BITS);
    end
  end

  // ---------------- Stage C: reference times mantissa
  logic                            vc_q;
  logic [ntf_pkg::PROD_W-1:0]      prod_c_q;
  logic signed [ntf_pkg::SH_W-1:0] sh_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (advance_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      prod_c_q <= ntf_pkg::PROD_W'(cfg_i.reference_hz) * ntf_pkg::PROD_W'(mant_b);
      sh_c_q   <= sh_b_q;
    end
  end

  // ---------------- Stage D: shift into Q format, round and clamp
  logic [ntf_pkg::SH_W-1:0]   rsh;
  logic [SW-1:0]              wide;
  logic [SW-1:0]              rnd;
  ntf_pkg::ntf_out_t          res_d;

  always_comb begin
    rsh   = ntf_pkg::SH_W'(-sh_c_q);
    wide  = '0;
    rnd   = '0;
    res_d = '0;
    if (prod_c_q == '0) begin
      res_d = '0;
    end else if (!sh_c_q[ntf_pkg::SH_W-1]) begin
      // left shift
      if (sh_c_q > ntf_pkg::SH_W'(ntf_pkg::FREQ_W - 1)) begin
        res_d.frequency = '1;
        res_d.saturated = 1'b1;
      end else begin
        wide = SW'(prod_c_q) << sh_c_q;
        if (|wide[SW-1:ntf_pkg::FREQ_W]) begin
          res_d.frequency = '1;
          res_d.saturated = 1'b1;
        end else begin
          res_d.frequency = wide[ntf_pkg::FREQ_W-1:0];
        end
      end
    end else if (rsh > ntf_pkg::SH_W'(ntf_pkg::PROD_W)) begin
      // the product is below half an output step
      res_d = '0;
    end else begin
      // right shift, round half up
      rnd  = SW'(1) << (rsh - ntf_pkg::SH_W'(1));
      wide = (SW'(prod_c_q) + rnd) >> rsh;
      if (|wide[SW-1:ntf_pkg::FREQ_W]) begin
        res_d.frequency = '1;
        res_d.saturated = 1'b1;
      end else begin
        res_d.frequency = wide[ntf_pkg::FREQ_W-1:0];
      end
    end
  end

  logic              vd_q;
  ntf_pkg::ntf_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (advance_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = vd_q;
  assign out_word_o  = out_q;

endmodule

// ===== src/note_to_frequency.sv =====
`timescale 1ns / 1ps

// Equal-temperament note to frequency converter. Each note word (octave,
// semitone) is transposed by the octave, semitone and cent offsets and turned
// into reference_hz * 2^(cents/1200) in unsigned Q16.16 Hz, clamped to all ones
// with saturated set on overflow. The block takes one word per cycle and returns
// its result through offset and octave split, mantissa memory read, reference
// multiply, then shift and round into the output register. A stall on the
// output holds the whole pipeline. After reset the 1200-entry mantissa memory
// is loaded from the constant table, one entry a cycle, and in_stall_o stays
// high until the last entry is written; configuration writes are taken at any
// time, but offsets and reference take effect correctly only while no note is
// in flight.
module note_to_frequency (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // note words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ntf_pkg::ntf_in_t               in_word_i,
  // frequency words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ntf_pkg::ntf_out_t              out_word_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ntf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ntf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  ntf_pkg::ntf_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.octave_offset   <= '0;
      cfg_q.semitone_offset <= '0;
      cfg_q.cent_offset     <= '0;
      cfg_q.reference_hz    <= ntf_pkg::REF_W'(440);
    end else if (cfg_valid_i) begin
      case (ntf_pkg::cfg_reg_e'(cfg_index_i))
        ntf_pkg::REG_OCTAVE_OFFSET:   cfg_q.octave_offset   <= $signed(cfg_data_i[3:0]);
        ntf_pkg::REG_SEMITONE_OFFSET: cfg_q.semitone_offset <= $signed(cfg_data_i[4:0]);
        ntf_pkg::REG_CENT_OFFSET:     cfg_q.cent_offset     <= $signed(cfg_data_i[7:0]);
        ntf_pkg::REG_REFERENCE_HZ:    cfg_q.reference_hz    <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  // Mantissa memory load after reset
  typedef enum logic [1:0] {
    ST_FILL = 2'b01,
    ST_RUN  = 2'b10
  } fill_state_e;

  fill_state_e                   state_q;
  logic [ntf_pkg::ROM_AW-1:0]    fill_cnt_q;
  logic                          fill_we_q;
  logic [ntf_pkg::ROM_AW-1:0]    fill_addr_q;
  logic [ntf_pkg::MANT_W-1:0]    fill_data_q;
  ntf_pkg::ntf_fill_t            fill;
  logic                          filling;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      fill_cnt_q <= '0;
      fill_we_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_FILL: begin
          fill_we_q  <= 1'b1;
          fill_cnt_q <= fill_cnt_q + 1'b1;
          if (fill_cnt_q == ntf_pkg::ROM_AW'(ntf_pkg::CENTS_PER_OCT - 1)) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          fill_we_q <= 1'b0;
        end
        default: begin
          state_q <= ST_FILL;
        end
      endcase
    end
  end

  // table lookup registered ahead of the memory write
  always_ff @(posedge clk_i) begin
    fill_addr_q <= fill_cnt_q;
    fill_data_q <= ntf_pkg::MANT_ROM[fill_cnt_q];
  end

  assign fill.we   = fill_we_q;
  assign fill.addr = fill_addr_q;
  assign fill.data = fill_data_q;
  assign filling   = (state_q == ST_FILL) || fill_we_q;

  // Pipeline flow: move when the output register is empty or being taken
  logic advance;
  logic in_fire;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance || filling;
  assign in_fire    = in_valid_i && !in_stall_o;

  ntf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fill_i      (fill),
    .advance_i   (advance),
    .in_fire_i   (in_fire),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule
